@@ hdl/isu_pkg.sv @@
// shared constants, codes and pixel blend functions of the scanline upscaler
package isu_pkg;

    // field widths
    localparam int PIX_W  = 32;
    localparam int POS_W  = 11;
    localparam int GEOM_W = 11;
    localparam int SEL_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // reset values of the configuration registers
    localparam logic [GEOM_W-1:0] RST_LINE_WIDTH   = 11'd320;
    localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = 11'd224;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd3;

    // pixel format codes
    localparam logic [SEL_W-1:0] FMT_RGB555 = 2'd0;
    localparam logic [SEL_W-1:0] FMT_RGB565 = 2'd1;
    localparam logic [SEL_W-1:0] FMT_RGB32  = 2'd2;

    // scan mode codes
    localparam logic [SEL_W-1:0] MODE_BLACK   = 2'd0;
    localparam logic [SEL_W-1:0] MODE_HALF    = 2'd1;
    localparam logic [SEL_W-1:0] MODE_3QUART  = 2'd2;

    // blend masks
    localparam logic [PIX_W-1:0] HALF_555    = 32'h0000_3DEF;
    localparam logic [PIX_W-1:0] HALF_565    = 32'h0000_7BEF;
    localparam logic [PIX_W-1:0] HALF_32     = 32'h7F7F_7F7F;
    localparam logic [PIX_W-1:0] QUART_555   = 32'h0000_1CE7;
    localparam logic [PIX_W-1:0] QUART_565   = 32'h0000_39E7;
    localparam logic [PIX_W-1:0] QUART_32    = 32'h3F3F_3F3F;

    // result kinds of one source pixel, in output order
    localparam int KINDS     = 6;
    localparam int K_BOT_L   = 0;   // bottom pair of the previous column, row above
    localparam int K_BOT_E   = 1;   // bottom pair at the right edge, row above
    localparam int K_TOP_L   = 2;   // top pair of the previous column
    localparam int K_TOP_E   = 3;   // top pair at the right edge
    localparam int K_LAST_L  = 4;   // bottom pair of the previous column, last line
    localparam int K_LAST_E  = 5;   // bottom pair at the right edge, last line

    typedef logic [KINDS-1:0] t_kind_mask;

    function automatic logic [PIX_W-1:0] half_mask(input logic [SEL_W-1:0] fmt);
        logic [PIX_W-1:0] m;
        unique case (fmt)
            FMT_RGB555: m = HALF_555;
            FMT_RGB565: m = HALF_565;
            default:    m = HALF_32;
        endcase
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] quarter_mask(input logic [SEL_W-1:0] fmt);
        logic [PIX_W-1:0] m;
        unique case (fmt)
            FMT_RGB555: m = QUART_555;
            FMT_RGB565: m = QUART_565;
            default:    m = QUART_32;
        endcase
        return m;
    endfunction

    // masked half-sum of two pixels
    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] m);
        return ((a >> 1) & m) + ((b >> 1) & m);
    endfunction

    // scanline intensity of the bottom row
    function automatic logic [PIX_W-1:0] darken(input logic [PIX_W-1:0] t,
                                                input logic [SEL_W-1:0] mode,
                                                input logic [SEL_W-1:0] fmt);
        logic [PIX_W-1:0] v;
        unique case (mode)
            MODE_HALF:   v = (t >> 1) & half_mask(fmt);
            MODE_3QUART: v = ((t >> 1) & half_mask(fmt)) + ((t >> 2) & quarter_mask(fmt));
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/isu_if.sv @@
// channel interfaces of the scanline upscaler: source pixels, output pairs, config writes

interface isu_pix_if;
    import isu_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;

    modport source (output valid, pixel_in, frame_start, input ready);
    modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface isu_res_if;
    import isu_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] left_value;
    logic [PIX_W-1:0] right_value;
    logic             last;

    modport source (output valid, out_row, out_col, left_value, right_value, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, left_value, right_value, last,
                    output ready);
endinterface

interface isu_cfg_if;
    import isu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/isu_ram.sv @@
// generic single-write, single-read ram with registered read-first output
module isu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents when both ports hit the same address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/interpolated_scanline_upscaler_top.sv @@
// top level of the interpolated scanline 2x upscaler
//
//  channel  | dir | handshake     | payload
//  i_pix    | in  | valid/ready   | pixel_in, frame_start
//  o_res    | out | valid/ready   | out_row, out_col, left_value, right_value, last
//  i_cfg    | in  | valid/ready   | index, data (ready always high)
//
//  one output pair leaves per cycle while the receiver is ready; a source pixel holds the pixel
//  stage until its pairs are emitted, from none up to six (two inside a line below the first),
//  and a pixel that makes none leaves at once. the first pair is registered in the result
//  register, behind the pixel stage. reset is synchronous; the line store is not cleared.
//  a new pixel is taken while the previous one emits its final pair; output stalls
//  back up through the result register into the pixel stage.
module interpolated_scanline_upscaler_top #(
    parameter int MAX_WIDTH  = isu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = isu_pkg::DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isu_pix_if.sink      i_pix,
    isu_res_if.source    o_res,
    isu_cfg_if.sink      i_cfg
);
    import isu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration registers
    logic [GEOM_W-1:0] r_line_width;
    logic [GEOM_W-1:0] r_frame_height;
    logic [SEL_W-1:0]  r_scan_mode;
    logic [SEL_W-1:0]  r_pixel_format;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // pixel stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_c;
    logic [RW-1:0]    r_s1_r;
    logic             r_s1_last_col;
    logic             r_s1_last_row;
    t_kind_mask       r_done;

    // neighbours carried from the previous pixel
    logic [PIX_W-1:0] r_left_pixel;
    logic [PIX_W-1:0] r_above_left;

    // result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_row;
    logic [POS_W-1:0] r_out_col;
    logic [PIX_W-1:0] r_out_left;
    logic [PIX_W-1:0] r_out_right;
    logic             r_out_last;

    logic             accept;
    logic [CW-1:0]    wm1;
    logic [RW-1:0]    hm1;
    logic [CW-1:0]    col_base;
    logic [RW-1:0]    row_base;
    logic [CW-1:0]    c_now;
    logic [RW-1:0]    r_now;
    logic             last_col_now;
    logic             last_row_now;
    logic [PIX_W-1:0] pix_now;
    logic [PIX_W-1:0] above;

    t_kind_mask       s1_mask;
    t_kind_mask       pending;
    t_kind_mask       sel;
    logic             out_free;
    logic             emit;
    logic             sel_last;
    logic             s1_retire;

    logic             is_bottom;
    logic [PIX_W-1:0] op_a;
    logic [PIX_W-1:0] op_b;
    logic [PIX_W-1:0] op_d;
    logic [PIX_W-1:0] op_dr;
    logic [POS_W-1:0] res_row;
    logic [POS_W-1:0] res_col;
    logic [CW:0]      c2;
    logic [RW:0]      r2;
    logic [POS_W-1:0] col_prev;
    logic [POS_W-1:0] col_here;
    logic [POS_W-1:0] row_up;
    logic [POS_W-1:0] row_top;
    logic [POS_W-1:0] row_down;
    logic [PIX_W-1:0] hm;
    logic [PIX_W-1:0] ab;
    logic [PIX_W-1:0] res_left;
    logic [PIX_W-1:0] res_right;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_scan_mode    <= MODE_BLACK;
            r_pixel_format <= FMT_RGB555;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                CFG_SCAN_MODE:    r_scan_mode    <= i_cfg.data[SEL_W-1:0];
                CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg.data[SEL_W-1:0];
                default:          r_line_width   <= r_line_width;
            endcase
        end
    end

    // clamped last column and last row
    always_comb begin
        if (r_line_width == '0) begin
            wm1 = '0;
        end else if (int'(r_line_width) > MAX_WIDTH) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(r_line_width - GEOM_W'(1));
        end
        if (r_frame_height == '0) begin
            hm1 = '0;
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(r_frame_height - GEOM_W'(1));
        end
    end

    // position of the incoming pixel
    always_comb begin
        col_base     = i_pix.frame_start ? '0 : r_col;
        row_base     = i_pix.frame_start ? '0 : r_row;
        c_now        = (col_base > wm1) ? wm1 : col_base;
        r_now        = (row_base > hm1) ? hm1 : row_base;
        last_col_now = (c_now == wm1);
        last_row_now = (r_now == hm1);
        pix_now      = (r_pixel_format == FMT_RGB555 || r_pixel_format == FMT_RGB565)
                       ? {16'h0000, i_pix.pixel_in[15:0]} : i_pix.pixel_in;
    end

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_s1_valid || s1_retire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col_now) begin
                r_col <= '0;
                r_row <= last_row_now ? '0 : r_now + RW'(1);
            end else begin
                r_col <= c_now + CW'(1);
                r_row <= r_now;
            end
        end
    end

    // line store: read the pixel above, write the current pixel in its place
    isu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (c_now),
        .i_wr_data (pix_now),
        .i_rd_en   (accept),
        .i_rd_addr (c_now),
        .o_rd_data (above)
    );

    // pixel stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_done     <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_done     <= '0;
        end else if (s1_retire) begin
            r_s1_valid <= 1'b0;
            r_done     <= '0;
        end else if (emit) begin
            r_done     <= r_done | sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= pix_now;
            r_s1_c        <= c_now;
            r_s1_r        <= r_now;
            r_s1_last_col <= last_col_now;
            r_s1_last_row <= last_row_now;
        end
    end

    // which pairs the staged pixel makes
    always_comb begin
        s1_mask           = '0;
        s1_mask[K_BOT_L]  = (r_s1_r != '0) && (r_s1_c != '0);
        s1_mask[K_BOT_E]  = (r_s1_r != '0) && r_s1_last_col;
        s1_mask[K_TOP_L]  = (r_s1_c != '0);
        s1_mask[K_TOP_E]  = r_s1_last_col;
        s1_mask[K_LAST_L] = r_s1_last_row && r_s1_last_col && (r_s1_c != '0);
        s1_mask[K_LAST_E] = r_s1_last_row && r_s1_last_col;
    end

    // pick the next pair in output order
    assign pending   = r_s1_valid ? (s1_mask & ~r_done) : '0;
    assign sel       = pending & (~pending + KINDS'(1));
    assign sel_last  = ((pending & ~sel) == '0);
    assign out_free  = !r_out_valid || o_res.ready;
    assign emit      = (pending != '0) && out_free;
    assign s1_retire = r_s1_valid && ((pending == '0) || (emit && sel_last));

    // carry neighbours forward when a pixel leaves the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_pixel <= '0;
            r_above_left <= '0;
        end else if (s1_retire) begin
            r_left_pixel <= r_s1_pix;
            r_above_left <= above;
        end
    end

    // destination coordinates
    always_comb begin
        c2       = {r_s1_c, 1'b0};
        r2       = {r_s1_r, 1'b0};
        col_prev = POS_W'(c2 - (CW + 1)'(2));
        col_here = POS_W'(c2);
        row_up   = POS_W'(r2 - (RW + 1)'(1));
        row_top  = POS_W'(r2);
        row_down = POS_W'(r2 + (RW + 1)'(1));
    end

    // operand selection for the chosen pair
    always_comb begin
        is_bottom = 1'b1;
        op_a      = r_s1_pix;
        op_b      = r_s1_pix;
        op_d      = r_s1_pix;
        op_dr     = r_s1_pix;
        res_row   = row_down;
        res_col   = col_here;
        priority if (sel[K_BOT_L]) begin
            op_a    = r_above_left;
            op_b    = above;
            op_d    = r_left_pixel;
            res_row = row_up;
            res_col = col_prev;
        end else if (sel[K_BOT_E]) begin
            op_a    = above;
            op_b    = above;
            res_row = row_up;
        end else if (sel[K_TOP_L]) begin
            is_bottom = 1'b0;
            op_a      = r_left_pixel;
            res_row   = row_top;
            res_col   = col_prev;
        end else if (sel[K_TOP_E]) begin
            is_bottom = 1'b0;
            res_row   = row_top;
        end else if (sel[K_LAST_L]) begin
            op_a    = r_left_pixel;
            op_d    = r_left_pixel;
            res_col = col_prev;
        end else begin
            // right edge of the last line, all operands are the pixel itself
            res_col = col_here;
        end
    end

    // shared blend datapath
    always_comb begin
        hm = half_mask(r_pixel_format);
        ab = blend(op_a, op_b, hm);
        if (is_bottom) begin
            res_left  = darken(blend(op_a, op_d, hm), r_scan_mode, r_pixel_format);
            res_right = darken(blend(ab, blend(op_d, op_dr, hm), hm),
                               r_scan_mode, r_pixel_format);
        end else begin
            res_left  = op_a;
            res_right = ab;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_left  <= res_left;
            r_out_right <= res_right;
            r_out_last  <= sel_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_row     = r_out_row;
    assign o_res.out_col     = r_out_col;
    assign o_res.left_value  = r_out_left;
    assign o_res.right_value = r_out_right;
    assign o_res.last        = r_out_last;

`ifndef NO_ASSERTIONS
    // a new pixel is taken only when at most the final pair of the staged one remains
    a_accept_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_s1_valid || $countones(pending) <= 1))
        else $error("pixel accepted while several pairs still pending");

    // emitted-pair record never runs ahead of the pairs the pixel makes
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((r_done & ~s1_mask) == '0))
        else $error("done mask holds a pair the pixel does not make");

    // a pixel with nothing left leaves the stage at once
    a_empty_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && pending == '0) |-> s1_retire)
        else $error("staged pixel with no pending pairs did not retire");

    // the pair flagged last closes out the staged pixel
    a_last_marks_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && sel_last) |=> (r_out_valid && r_out_last))
        else $error("final pair of a pixel not flagged last");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench of the interpolated scanline upscaler: class-based pair prediction and checking
`timescale 1ns / 1ps

module testbench;
    import isu_pkg::*;

    // codes outside the defined set, handled as their fallbacks
    localparam logic [SEL_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [SEL_W-1:0] FMT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic             last;
    } t_pair;

    // predicts the output pairs of each accepted pixel and checks them in order
    class t_pair_scoreboard;
        logic [GEOM_W-1:0] width_cfg;
        logic [GEOM_W-1:0] height_cfg;
        logic [SEL_W-1:0]  mode_cfg;
        logic [SEL_W-1:0]  fmt_cfg;
        logic [PIX_W-1:0]  line_mem [DEF_MAX_WIDTH];
        bit                line_written [DEF_MAX_WIDTH];
        logic [PIX_W-1:0]  left_pix;
        logic [PIX_W-1:0]  upper_left;
        int unsigned       col_cnt;
        int unsigned       row_cnt;
        t_pair             expected_pairs [$];
        int                errors;

        function new();
            width_cfg  = RST_LINE_WIDTH;
            height_cfg = RST_FRAME_HEIGHT;
            mode_cfg   = MODE_BLACK;
            fmt_cfg    = FMT_RGB555;
            foreach (line_mem[i]) begin
                line_mem[i]     = '0;
                line_written[i] = 1'b0;
            end
            left_pix   = '0;
            upper_left = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LINE_WIDTH:   width_cfg  = value;
                CFG_FRAME_HEIGHT: height_cfg = value;
                CFG_SCAN_MODE:    mode_cfg   = value[SEL_W-1:0];
                CFG_PIXEL_FORMAT: fmt_cfg    = value[SEL_W-1:0];
            endcase
        endfunction

        function int unsigned active_width();
            if (width_cfg == 0) return 1;
            if (width_cfg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return width_cfg;
        endfunction

        function int unsigned active_height();
            if (height_cfg == 0) return 1;
            if (height_cfg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
            return height_cfg;
        endfunction

        // position the next pixel lands on, counters clamped to the geometry
        function void next_position(bit fs, output int unsigned c, output int unsigned r);
            c = fs ? 0 : col_cnt;
            r = fs ? 0 : row_cnt;
            if (c > active_width() - 1) c = active_width() - 1;
            if (r > active_height() - 1) r = active_height() - 1;
        endfunction

        // false when the pixel would blend with a line store entry never written
        function bit line_ready(bit fs);
            int unsigned c;
            int unsigned r;
            next_position(fs, c, r);
            return !(r > 0 && !line_written[c]);
        endfunction

        function logic [PIX_W-1:0] fmt_half_mask();
            case (fmt_cfg)
                FMT_RGB555: return HALF_555;
                FMT_RGB565: return HALF_565;
                default:    return HALF_32;
            endcase
        endfunction

        function logic [PIX_W-1:0] fmt_quarter_mask();
            case (fmt_cfg)
                FMT_RGB555: return QUART_555;
                FMT_RGB565: return QUART_565;
                default:    return QUART_32;
            endcase
        endfunction

        function logic [PIX_W-1:0] mix(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] m;
            m = fmt_half_mask();
            return ((a >> 1) & m) + ((b >> 1) & m);
        endfunction

        // scanline intensity
        function logic [PIX_W-1:0] dim(logic [PIX_W-1:0] t);
            logic [PIX_W-1:0] hm;
            logic [PIX_W-1:0] qm;
            hm = fmt_half_mask();
            qm = fmt_quarter_mask();
            case (mode_cfg)
                MODE_HALF:   return (t >> 1) & hm;
                MODE_3QUART: return ((t >> 1) & hm) + ((t >> 2) & qm);
                default:     return '0;
            endcase
        endfunction

        function void add_pair(int unsigned row, int unsigned col,
                               logic [PIX_W-1:0] lv, logic [PIX_W-1:0] rv);
            t_pair e;
            e.row   = row[POS_W-1:0];
            e.col   = col[POS_W-1:0];
            e.left  = lv;
            e.right = rv;
            e.last  = 1'b0;
            expected_pairs.push_back(e);
        endfunction

        function void add_top(int unsigned row, int unsigned col,
                              logic [PIX_W-1:0] c, logic [PIX_W-1:0] r);
            add_pair(row, col, c, mix(c, r));
        endfunction

        function void add_bottom(int unsigned row, int unsigned col,
                                 logic [PIX_W-1:0] c, logic [PIX_W-1:0] r,
                                 logic [PIX_W-1:0] d, logic [PIX_W-1:0] dr);
            add_pair(row, col, dim(mix(c, d)), dim(mix(mix(c, r), mix(d, dr))));
        endfunction

        // accepted pixel transaction: predict its pairs and advance the raster
        function void note_pixel(logic [PIX_W-1:0] pixel, bit fs);
            int unsigned      c;
            int unsigned      r;
            int unsigned      prior_count;
            bit               last_col;
            bit               last_row;
            logic [PIX_W-1:0] p;
            logic [PIX_W-1:0] above;
            t_pair            tail;
            p = pixel;
            if (fmt_cfg == FMT_RGB555 || fmt_cfg == FMT_RGB565) p[PIX_W-1:16] = '0;
            next_position(fs, c, r);
            last_col    = (c == active_width() - 1);
            last_row    = (r == active_height() - 1);
            above       = line_mem[c];
            prior_count = expected_pairs.size();

            if (r > 0 && c > 0) add_bottom(2*r - 1, 2*(c - 1), upper_left, above, left_pix, p);
            if (r > 0 && last_col) add_bottom(2*r - 1, 2*c, above, above, p, p);
            if (c > 0) add_top(2*r, 2*(c - 1), left_pix, p);
            if (last_col) add_top(2*r, 2*c, p, p);
            if (last_row && last_col) begin
                if (c > 0) add_bottom(2*r + 1, 2*(c - 1), left_pix, p, left_pix, p);
                add_bottom(2*r + 1, 2*c, p, p, p, p);
            end
            if (expected_pairs.size() > prior_count) begin
                tail = expected_pairs.pop_back();
                tail.last = 1'b1;
                expected_pairs.push_back(tail);
            end

            line_mem[c]     = p;
            line_written[c] = 1'b1;
            upper_left      = above;
            left_pix        = p;
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // accepted result transaction against the oldest expected pair
        function void check_pair(t_pair got);
            t_pair want;
            if (expected_pairs.size() == 0) begin
                $display("%0t: pair with none expected, expected nothing, actual row %0d col %0d",
                         $time, got.row, got.col);
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            compare_field("out_row", want.row, got.row);
            compare_field("out_col", want.col, got.col);
            compare_field("left_value", want.left, got.left);
            compare_field("right_value", want.right, got.right);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isu_pix_if pix_ch ();
    isu_res_if res_ch ();
    isu_cfg_if cfg_ch ();

    interpolated_scanline_upscaler_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    t_pair_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               recv_hold;

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver ready, with random stalls and long hold-offs
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (recv_hold > 0) begin
                res_ch.ready <= 1'b0;
                recv_hold--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    initial begin
        t_pair got;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got.row   = res_ch.out_row;
                got.col   = res_ch.out_col;
                got.left  = res_ch.left_value;
                got.right = res_ch.right_value;
                got.last  = res_ch.last;
                sb.check_pair(got);
            end
        end
    end

    // one pixel transaction; a start is forced where the line store is not yet filled
    task automatic send_pixel(logic [PIX_W-1:0] pixel, bit fs);
        if (!sb.line_ready(fs)) fs = 1'b1;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_in    <= pixel;
        pix_ch.frame_start <= fs;
        do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
        sb.note_pixel(pixel, fs);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h,
                                logic [SEL_W-1:0] mode, logic [SEL_W-1:0] fmt);
        write_register(CFG_LINE_WIDTH, w[CFG_DATA_W-1:0]);
        write_register(CFG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
        write_register(CFG_SCAN_MODE, CFG_DATA_W'(mode));
        write_register(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    endtask

    // stop offering pixels and let every expected pair drain
    task automatic wait_drained();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_phase();
        int unsigned      w;
        int unsigned      h;
        int               n;
        bit               fs;
        logic [PIX_W-1:0] pixel;
        case ($urandom_range(19))
            0:       w = 0;
            1:       w = DEF_MAX_WIDTH;
            2:       w = 2047;
            3, 4, 5: w = $urandom_range(7, 40);
            default: w = $urandom_range(1, 6);
        endcase
        case ($urandom_range(19))
            0:       h = 0;
            1:       h = DEF_MAX_HEIGHT;
            2:       h = 2047;
            default: h = $urandom_range(1, 4);
        endcase
        set_geometry(w, h, SEL_W'($urandom_range(3)), SEL_W'($urandom_range(3)));
        n = $urandom_range(9, 12);
        for (int i = 0; i < n; i++) begin
            fs = (i == 0 && $urandom_range(99) < 75) || ($urandom_range(99) < 4);
            case ($urandom_range(9))
                0:       pixel = '0;
                1:       pixel = '1;
                default: pixel = $urandom;
            endcase
            send_pixel(pixel, fs);
        end
    endtask

    // stimulus
    initial begin
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_in    = '0;
        pix_ch.frame_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_LINE_WIDTH;
        cfg_ch.data        = '0;
        rst_n              = 1'b0;
        sb                 = new();
        send_idle_pct      = 31;
        recv_idle_pct      = 48;
        recv_hold          = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-pixel frames, upper half of a 16-bit pixel dropped
        set_geometry(1, 1, MODE_HALF, FMT_RGB555);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);

        // 3x2 frame, last pixel makes all six pairs
        wait_drained();
        set_geometry(3, 2, MODE_3QUART, FMT_RGB565);
        send_pixel(32'h0000_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h1234_ABCD, 1'b0);
        send_pixel(32'h8000_FFFF, 1'b0);
        send_pixel(32'h0000_FFFF, 1'b0);
        send_pixel(32'h5A5A_5A5A, 1'b0);

        // height above the maximum, then a frame start in the middle of a line
        wait_drained();
        set_geometry(2, 2047, MODE_BLACK, FMT_RGB32);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'h7FFF_FFFF, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h0F0F_0F0F, 1'b1);

        // zero geometry while mid-line: counter clamps to the last position
        wait_drained();
        set_geometry(0, 0, MODE_UNUSED, FMT_UNUSED);
        send_pixel(32'hA5A5_A5A5, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);

        // width above the maximum
        wait_drained();
        set_geometry(2047, 1, MODE_3QUART, FMT_RGB32);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);

        // random frames under three idling regimes
        for (int regime = 0; regime < 3; regime++) begin
            for (int ph = 0; ph < 3; ph++) begin
                wait_drained();
                case (regime)
                    0: begin
                        send_idle_pct = 31;
                        recv_idle_pct = 48;
                    end
                    1: begin
                        send_idle_pct = 48;
                        recv_idle_pct = 31;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                // long receiver hold-off so the block backs up into its input
                if (regime == 2 && ph == 0) recv_hold = 150;
                random_phase();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
